// ===== rtl/core/lpdm_pkg.sv =====
// Shared types and constants for the longest prefix dictionary match unit.
`default_nettype none
package lpdm_pkg;

    localparam int ENTRIES_DEF  = 64;
    localparam int MAX_NAME_DEF = 16;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_LENGTH = 2'd1;
    localparam logic [1:0] REQ_TOKEN  = 2'd2;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_LENGTH = 2'd1;
    localparam logic [1:0] CMD_TOKEN  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] idx;
        logic [3:0] pos;
        logic [7:0] ch;
        logic [4:0] len;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic       matched;
        logic [4:0] match_length;
        logic [5:0] matched_entry;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/lpdm_front.sv =====
// Front end: classify incoming transactions and queue the ones that do work.
`default_nettype none
module lpdm_front #(
    parameter int ENTRIES  = lpdm_pkg::ENTRIES_DEF,
    parameter int MAX_NAME = lpdm_pkg::MAX_NAME_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [1:0]      i_req_type,
    input  wire logic [5:0]      i_entry_index,
    input  wire logic [3:0]      i_char_pos,
    input  wire logic [7:0]      i_name_char,
    input  wire logic [4:0]      i_name_length,
    input  wire logic [7:0]      i_token_char,
    input  wire logic            i_last_char,
    output logic                 o_cmd_valid,
    output lpdm_pkg::t_cmd       o_cmd,
    input  wire logic            i_cmd_pop
);

    localparam int QW = $clog2(lpdm_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(lpdm_pkg::QUEUE_DEPTH + 1);

    lpdm_pkg::t_cmd r_q [lpdm_pkg::QUEUE_DEPTH];
    logic [QW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    lpdm_pkg::t_cmd w_cmd;
    logic           w_keep;
    logic           w_push;
    logic           w_pop;
    logic           w_idx_ok;
    logic           w_pos_ok;

    always_comb begin
        w_idx_ok = 32'(i_entry_index) < ENTRIES;
        w_pos_ok = 32'(i_char_pos) < MAX_NAME;
        w_cmd.kind = lpdm_pkg::CMD_TOKEN;
        w_cmd.idx  = i_entry_index;
        w_cmd.pos  = i_char_pos;
        w_cmd.ch   = i_token_char;
        w_cmd.last = i_last_char;
        w_cmd.len  = (32'(i_name_length) > MAX_NAME) ? 5'(MAX_NAME) : i_name_length;
        w_keep = 1'b0;
        unique case (i_req_type)
            lpdm_pkg::REQ_WRITE: begin
                w_cmd.kind = lpdm_pkg::CMD_WRITE;
                w_cmd.ch   = i_name_char;
                w_keep     = w_idx_ok && w_pos_ok;
            end
            lpdm_pkg::REQ_LENGTH: begin
                w_cmd.kind = lpdm_pkg::CMD_LENGTH;
                w_keep     = w_idx_ok;
            end
            lpdm_pkg::REQ_TOKEN: begin
                w_keep = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_ready     = r_count != CW'(lpdm_pkg::QUEUE_DEPTH);
    assign w_push      = i_valid && o_ready && w_keep;
    assign o_cmd_valid = r_count != '0;
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/lpdm_back.sv =====
// Back end: name memory, entry lengths, token match and result register.
`default_nettype none
module lpdm_back #(
    parameter int ENTRIES  = lpdm_pkg::ENTRIES_DEF,
    parameter int MAX_NAME = lpdm_pkg::MAX_NAME_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  lpdm_pkg::t_cmd     i_cmd,
    output logic               o_cmd_pop,
    output logic               o_res_valid,
    output lpdm_pkg::t_result  o_res,
    input  wire logic          i_res_ready
);

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
    localparam int LW = $clog2(MAX_NAME + 1);

    logic [ENTRIES*8-1:0] r_mem [MAX_NAME];
    logic [ENTRIES*8-1:0] r_row;
    logic [LW-1:0]        r_len [ENTRIES];
    logic [ENTRIES-1:0]   r_alive;
    logic [LW-1:0]        r_tpos;
    logic [LW-1:0]        r_best_len;
    logic [EW-1:0]        r_best_ent;
    logic                 r_cmp;
    logic                 r_cmp_last;
    logic [7:0]           r_cmp_char;
    logic                 r_res_valid;
    lpdm_pkg::t_result    r_res;

    logic                 w_out_free;
    logic                 w_tok_sat;
    logic                 w_pop;
    logic                 w_cmp_go;
    logic [ENTRIES-1:0]   w_kill;
    logic [ENTRIES-1:0]   w_cand;
    logic                 w_any;
    logic [EW-1:0]        w_first;
    logic [LW-1:0]        w_next_pos;
    logic [LW-1:0]        n_best_len;
    logic [EW-1:0]        n_best_ent;
    logic [PW-1:0]        w_wr_row;
    logic [EW-1:0]        w_wr_col;

    assign w_out_free = !r_res_valid || i_res_ready;
    assign w_tok_sat  = 32'(r_tpos) >= MAX_NAME;
    assign w_pop      = i_cmd_valid && !r_cmp &&
                        !(i_cmd.kind == lpdm_pkg::CMD_TOKEN && w_tok_sat &&
                          i_cmd.last && !w_out_free);
    assign o_cmd_pop  = w_pop;
    assign w_cmp_go   = r_cmp && (!r_cmp_last || w_out_free);
    assign w_wr_row   = PW'(i_cmd.pos);
    assign w_wr_col   = EW'(i_cmd.idx);
    assign w_next_pos = LW'(r_tpos + 1'b1);

    always_comb begin
        for (int e = 0; e < ENTRIES; e++) begin
            logic live;
            logic same;
            live = r_alive[e] && (r_len[e] != '0) && (r_tpos < r_len[e]);
            same = r_row[e*8 +: 8] == r_cmp_char;
            w_kill[e] = live && !same;
            w_cand[e] = live && same && (r_len[e] == w_next_pos);
        end
        w_any   = |w_cand;
        w_first = '0;
        for (int e = ENTRIES - 1; e >= 0; e--) begin
            if (w_cand[e]) begin
                w_first = EW'(e);
            end
        end
        n_best_len = w_any ? w_next_pos : r_best_len;
        n_best_ent = w_any ? w_first : r_best_ent;
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_cmd.kind == lpdm_pkg::CMD_WRITE) begin
            r_mem[w_wr_row][w_wr_col*8 +: 8] <= i_cmd.ch;
        end
        if (w_pop && i_cmd.kind == lpdm_pkg::CMD_TOKEN) begin
            r_row <= r_mem[r_tpos[PW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_cmd.kind == lpdm_pkg::CMD_TOKEN) begin
            r_cmp_last <= i_cmd.last;
            r_cmp_char <= i_cmd.ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < ENTRIES; e++) begin
                r_len[e] <= '0;
            end
            r_alive     <= '1;
            r_tpos      <= '0;
            r_best_len  <= '0;
            r_best_ent  <= '0;
            r_cmp       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (w_pop && i_cmd.kind == lpdm_pkg::CMD_LENGTH) begin
                r_len[w_wr_col] <= LW'(i_cmd.len);
            end
            if (w_pop && i_cmd.kind == lpdm_pkg::CMD_TOKEN) begin
                if (!w_tok_sat) begin
                    r_cmp <= 1'b1;
                end else if (i_cmd.last) begin
                    r_res_valid         <= 1'b1;
                    r_res.matched       <= r_best_len != '0;
                    r_res.match_length  <= 5'(r_best_len);
                    r_res.matched_entry <= 6'(r_best_ent);
                    r_alive    <= '1;
                    r_tpos     <= '0;
                    r_best_len <= '0;
                    r_best_ent <= '0;
                end
            end
            if (w_cmp_go) begin
                r_cmp <= 1'b0;
                if (r_cmp_last) begin
                    r_res_valid         <= 1'b1;
                    r_res.matched       <= n_best_len != '0;
                    r_res.match_length  <= 5'(n_best_len);
                    r_res.matched_entry <= 6'(n_best_ent);
                    r_alive    <= '1;
                    r_tpos     <= '0;
                    r_best_len <= '0;
                    r_best_ent <= '0;
                end else begin
                    r_alive    <= r_alive & ~w_kill;
                    r_tpos     <= w_next_pos;
                    r_best_len <= n_best_len;
                    r_best_ent <= n_best_ent;
                end
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
`default_nettype wire

// ===== rtl/core/longest_prefix_dictionary_match_unit.sv =====
// Top level of the longest prefix dictionary match unit.
// Loads a dictionary of names one character at a time and streams tokens
// against it, one character per transaction; on a token's last character one
// result gives whether a name matched, its length and its entry index. The
// input side feeds a four-deep command queue, so writes and token characters
// are taken while the match engine works. In the engine a name write or a
// length write is stored when popped; a token character short of MAX_NAME
// reads the row of the name memory at the current token position for all
// entries, then compares the row and updates the best match. Results wait in
// an output register without stalling the queue until another result is due.
`default_nettype none
module longest_prefix_dictionary_match_unit #(
    parameter int ENTRIES  = lpdm_pkg::ENTRIES_DEF,
    parameter int MAX_NAME = lpdm_pkg::MAX_NAME_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // entry_index[5:0], char_pos[9:6], name_char[17:10], name_length[22:18],
    // token_char[30:23], zero [31]
    input  wire logic [31:0] i_s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  i_s_tuser,
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // matched[0], match_length[5:1], matched_entry[11:6], zero [15:12]
    output logic [15:0]      o_m_tdata
);

    logic              w_cmd_valid;
    lpdm_pkg::t_cmd    w_cmd;
    logic              w_cmd_pop;
    lpdm_pkg::t_result w_res;

    lpdm_front #(
        .ENTRIES  (ENTRIES),
        .MAX_NAME (MAX_NAME)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_req_type    (i_s_tuser),
        .i_entry_index (i_s_tdata[5:0]),
        .i_char_pos    (i_s_tdata[9:6]),
        .i_name_char   (i_s_tdata[17:10]),
        .i_name_length (i_s_tdata[22:18]),
        .i_token_char  (i_s_tdata[30:23]),
        .i_last_char   (i_s_tlast),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    lpdm_back #(
        .ENTRIES  (ENTRIES),
        .MAX_NAME (MAX_NAME)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_valid (o_m_tvalid),
        .o_res       (w_res),
        .i_res_ready (i_m_tready)
    );

    assign o_m_tdata = {4'd0, w_res.matched_entry, w_res.match_length, w_res.matched};

endmodule
`default_nettype wire
